// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the cartesian-to-polar RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("c2p assertion failed");

// Implication from an antecedent to a consequent sequence outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2p assertion failed");

`endif

// ===== rtl/c2p_pkg.sv =====
// Package with shared constants, types and the arctangent table of the converter.
`timescale 1ns / 1ps

package c2p_pkg;

    // Width of the angle result and of the internal turn accumulator.
    localparam int ANGLE_W    = 16;
    localparam int TURN_W     = 32;
    localparam int GUARD_BITS = 16;

    // Fixed angles used on the axes.
    localparam logic [ANGLE_W-1:0] ANG_ZERO          = 16'h0000;
    localparam logic [ANGLE_W-1:0] ANG_QUARTER       = 16'h4000;
    localparam logic [ANGLE_W-1:0] ANG_HALF          = 16'h8000;
    localparam logic [ANGLE_W-1:0] ANG_THREE_QUARTER = 16'hC000;
    localparam logic [TURN_W-1:0]  TURN_HALF         = 32'h8000_0000;

    // Axis and sign flags that travel with an item through the angle pipeline.
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
    } c2p_flags_t;

    // atan(2^-i) in units of 2^-32 of a full turn, truncated.
    function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
        logic [TURN_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 32'h2000_0000;
                5'd1:    val = 32'h12E4_051E;
                5'd2:    val = 32'h09FB_385B;
                5'd3:    val = 32'h0511_11D4;
                5'd4:    val = 32'h028B_0D43;
                5'd5:    val = 32'h0145_D7E1;
                5'd6:    val = 32'h00A2_F61E;
                5'd7:    val = 32'h0051_7C55;
                5'd8:    val = 32'h0028_BE53;
                5'd9:    val = 32'h0014_5F2F;
                5'd10:   val = 32'h000A_2F98;
                5'd11:   val = 32'h0005_17CC;
                5'd12:   val = 32'h0002_8BE6;
                5'd13:   val = 32'h0001_45F3;
                5'd14:   val = 32'h0000_A2F9;
                5'd15:   val = 32'h0000_517C;
                5'd16:   val = 32'h0000_28BE;
                5'd17:   val = 32'h0000_145F;
                5'd18:   val = 32'h0000_0A2F;
                5'd19:   val = 32'h0000_0517;
                5'd20:   val = 32'h0000_028B;
                5'd21:   val = 32'h0000_0145;
                5'd22:   val = 32'h0000_00A2;
                5'd23:   val = 32'h0000_0051;
                5'd24:   val = 32'h0000_0028;
                5'd25:   val = 32'h0000_0014;
                5'd26:   val = 32'h0000_000A;
                5'd27:   val = 32'h0000_0005;
                5'd28:   val = 32'h0000_0002;
                5'd29:   val = 32'h0000_0001;
                default: val = 32'h0000_0000;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/c2p_mag_pipe.sv =====
// Pipelined magnitude unit: squares, sum and one square-root digit per stage.
`timescale 1ns / 1ps

module c2p_mag_pipe #(
    parameter int CW  = 16,
    parameter int PAD = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic                 out_valid,
    output logic [CW-1:0]        magnitude
);
    import c2p_pkg::*;

    // Remainder width: the final remainder is at most twice the root.
    localparam int RW = CW + 2;
    localparam int NW = 2 * CW;

    logic signed [NW-1:0] sqx_s;
    logic signed [NW-1:0] sqy_s;
    logic [NW-1:0]        sqx_reg;
    logic [NW-1:0]        sqy_reg;
    logic                 sq_vld_reg;

    logic [NW-1:0]        n_reg    [0:CW];
    logic [CW-1:0]        root_reg [0:CW];
    logic [RW-1:0]        rem_reg  [0:CW];
    logic                 vld_reg  [0:CW];

    logic [CW-1:0]        mag_next;
    logic [CW-1:0]        mag_reg  [0:PAD];
    logic                 mvld_reg [0:PAD];

    // Squares of the coordinates; both fit the double width exactly.
    always_comb
    begin
        sqx_s = x_in * x_in;
        sqy_s = y_in * y_in;
    end

    always_ff @(posedge clk)
    begin
        sqx_reg    <= $unsigned(sqx_s);
        sqy_reg    <= $unsigned(sqy_s);
        n_reg[0]    <= sqx_reg + sqy_reg;
        root_reg[0] <= '0;
        rem_reg[0]  <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= in_valid;
            vld_reg[0] <= sq_vld_reg;
        end
    end

    // One root bit per stage, taking two bits of the radicand at a time.
    for (genvar k = 0; k < CW; k++)
    begin : g_sqrt
        logic [1:0]    pair;
        logic [RW-1:0] rem_t;
        logic [RW-1:0] trial;
        logic [NW-1:0] n_next;
        logic [CW-1:0] root_next;
        logic [RW-1:0] rem_next;

        always_comb
        begin
            pair   = n_reg[k][NW-1 -: 2];
            n_next = n_reg[k] << 2;
            rem_t  = {rem_reg[k][RW-3:0], pair};
            trial  = {root_reg[k], 2'b01};
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[k][CW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {root_reg[k][CW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k+1]    <= n_next;
            root_reg[k+1] <= root_next;
            rem_reg[k+1]  <= rem_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    // Round to nearest: step up when the remainder exceeds the root.
    always_comb
    begin
        mag_next = root_reg[CW]
                 + {{(CW-1){1'b0}}, (rem_reg[CW] > {2'b00, root_reg[CW]})};
    end

    always_ff @(posedge clk)
    begin
        mag_reg[0] <= mag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvld_reg[0] <= 1'b0;
        end
        else
        begin
            mvld_reg[0] <= vld_reg[CW];
        end
    end

    // Delay stages that align this path with the angle path.
    for (genvar p = 0; p < PAD; p++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            mag_reg[p+1] <= mag_reg[p];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mvld_reg[p+1] <= 1'b0;
            end
            else
            begin
                mvld_reg[p+1] <= mvld_reg[p];
            end
        end
    end

    assign magnitude = mag_reg[PAD];
    assign out_valid = mvld_reg[PAD];

endmodule

// ===== rtl/c2p_cordic_pipe.sv =====
// Pipelined CORDIC vectoring unit: one micro rotation per stage, then axis cases.
`timescale 1ns / 1ps

module c2p_cordic_pipe #(
    parameter int CW    = 16,
    parameter int STEPS = 16,
    parameter int PAD   = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [CW-1:0]            x_in,
    input  logic signed [CW-1:0]            y_in,
    output logic                            out_valid,
    output logic [c2p_pkg::ANGLE_W-1:0]     angle,
    output logic                            angle_valid
);
    import c2p_pkg::*;

    // Datapath width: guard bits plus headroom for the CORDIC gain.
    localparam int DW = CW + GUARD_BITS + 3;

    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] y_ext;
    logic signed [DW-1:0] x_pre;
    logic signed [DW-1:0] y_pre;
    logic [TURN_W-1:0]    z_pre;
    c2p_flags_t           flg_pre;

    logic signed [DW-1:0] x_reg   [0:STEPS];
    logic signed [DW-1:0] y_reg   [0:STEPS];
    logic [TURN_W-1:0]    z_reg   [0:STEPS];
    c2p_flags_t           flg_reg [0:STEPS];
    logic                 vld_reg [0:STEPS];

    logic [ANGLE_W-1:0]   ang_next;
    logic                 av_next;
    logic [ANGLE_W-1:0]   ang_reg  [0:PAD];
    logic                 av_reg   [0:PAD];
    logic                 avld_reg [0:PAD];

    // Fold the left half plane onto the right and add the guard bits.
    always_comb
    begin
        x_ext          = {{(DW-CW){x_in[CW-1]}}, x_in};
        y_ext          = {{(DW-CW){y_in[CW-1]}}, y_in};
        flg_pre.x_zero = (x_in == '0);
        flg_pre.y_zero = (y_in == '0);
        flg_pre.x_neg  = x_in[CW-1];
        flg_pre.y_neg  = y_in[CW-1];
        if (x_in[CW-1])
        begin
            x_pre = -x_ext;
            y_pre = -y_ext;
            z_pre = TURN_HALF;
        end
        else
        begin
            x_pre = x_ext;
            y_pre = y_ext;
            z_pre = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= x_pre <<< GUARD_BITS;
        y_reg[0]   <= y_pre <<< GUARD_BITS;
        z_reg[0]   <= z_pre;
        flg_reg[0] <= flg_pre;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    // Micro rotations: drive y toward zero and accumulate the turned angle.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        logic signed [DW-1:0] xs;
        logic signed [DW-1:0] ys;
        logic signed [DW-1:0] x_next;
        logic signed [DW-1:0] y_next;
        logic [TURN_W-1:0]    z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (!y_reg[i][DW-1])
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + atan_turn(5'(i));
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - atan_turn(5'(i));
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]   <= x_next;
            y_reg[i+1]   <= y_next;
            z_reg[i+1]   <= z_next;
            flg_reg[i+1] <= flg_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    // Origin and axis points take exact angles; others round the accumulator.
    always_comb
    begin
        av_next = 1'b1;
        if (flg_reg[STEPS].x_zero && flg_reg[STEPS].y_zero)
        begin
            ang_next = ANG_ZERO;
            av_next  = 1'b0;
        end
        else if (flg_reg[STEPS].x_zero)
        begin
            ang_next = flg_reg[STEPS].y_neg ? ANG_THREE_QUARTER : ANG_QUARTER;
        end
        else if (flg_reg[STEPS].y_zero)
        begin
            ang_next = flg_reg[STEPS].x_neg ? ANG_HALF : ANG_ZERO;
        end
        else
        begin
            ang_next = z_reg[STEPS][TURN_W-1 -: ANGLE_W]
                     + {{(ANGLE_W-1){1'b0}}, z_reg[STEPS][TURN_W-ANGLE_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= ang_next;
        av_reg[0]  <= av_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avld_reg[0] <= 1'b0;
        end
        else
        begin
            avld_reg[0] <= vld_reg[STEPS];
        end
    end

    // Delay stages that align this path with the magnitude path.
    for (genvar p = 0; p < PAD; p++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            ang_reg[p+1] <= ang_reg[p];
            av_reg[p+1]  <= av_reg[p];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                avld_reg[p+1] <= 1'b0;
            end
            else
            begin
                avld_reg[p+1] <= avld_reg[p];
            end
        end
    end

    assign angle       = ang_reg[PAD];
    assign angle_valid = av_reg[PAD];
    assign out_valid   = avld_reg[PAD];

endmodule

// ===== rtl/cartesian_to_polar_top.sv =====
// Top level of the pipelined Cartesian to polar converter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts one signed point (x_coord, y_coord) per clock into its rounded
// magnitude and its angle in units of 2pi/65536 in [0, 2pi). A new item is
// taken in every cycle; busy is always low. The result of an accepted item
// appears with done high for exactly one cycle, in the order the items came
// in. The receiver cannot stall the block and must take each result in the
// cycle that done marks. Both results wait for the longer of the two parallel
// pipelines: the square-root pipeline with one root bit per stage, and the
// CORDIC pipeline with one micro rotation per stage. The origin gives
// magnitude 0, angle 0 and angle_valid low.
module cartesian_to_polar_top #(
    parameter int COORD_WIDTH    = 16,
    parameter int ROTATION_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          done,
    output logic [COORD_WIDTH-1:0]        magnitude,
    output logic [c2p_pkg::ANGLE_W-1:0]   angle,
    output logic                          angle_valid
);
    import c2p_pkg::*;

    localparam int MAG_LAT = COORD_WIDTH + 3;
    localparam int ANG_LAT = ROTATION_STEPS + 2;
    localparam int LAT     = (MAG_LAT > ANG_LAT) ? MAG_LAT : ANG_LAT;

    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic                          in_vld_reg;
    logic                          mag_valid;
    logic                          ang_valid;

    // The pipeline never stalls, so an item is always taken.
    assign busy = 1'b0;

    // Input item register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_coord;
            y_reg <= y_coord;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    // Magnitude path.
    c2p_mag_pipe #(
        .CW  (COORD_WIDTH),
        .PAD (LAT - MAG_LAT)
    ) u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .x_in      (x_reg),
        .y_in      (y_reg),
        .out_valid (mag_valid),
        .magnitude (magnitude)
    );

    // Angle path.
    c2p_cordic_pipe #(
        .CW    (COORD_WIDTH),
        .STEPS (ROTATION_STEPS),
        .PAD   (LAT - ANG_LAT)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_vld_reg),
        .x_in        (x_reg),
        .y_in        (y_reg),
        .out_valid   (ang_valid),
        .angle       (angle),
        .angle_valid (angle_valid)
    );

    assign done = ang_valid;

    // Both paths must deliver the same item in the same cycle.
    `ASSERT_ALWAYS(a_paths_aligned, clk, rst_n, mag_valid == ang_valid)
    // An accepted item raises done once it has passed the input register and the longer pipeline.
    `ASSERT_IMPLY(a_latency, clk, rst_n, start && !busy, ##(LAT + 1) done)
    // The origin gives zero magnitude and zero angle.
    `ASSERT_IMPLY(a_origin, clk, rst_n, done && !angle_valid, magnitude == '0 && angle == '0)
    // Any other point has a nonzero magnitude.
    `ASSERT_IMPLY(a_nonzero, clk, rst_n, done && angle_valid, magnitude != '0)

endmodule

// ===== dv/cartesian_to_polar_top_tb.sv =====
// Self-checking testbench for the pipelined Cartesian to polar converter.
`timescale 1ns / 1ps

module cartesian_to_polar_top_tb;

    import c2p_pkg::*;

    localparam int COORD_W      = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int LATENCY      = 19;
    localparam int DRAIN_CYCLES = 2 * LATENCY + 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_N   = 24;

    // Rotation angles atan(2^-k) in units of 2^-32 of a full turn, truncated.
    localparam logic [31:0] ATAN_STEP_TURNS [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C
    };

    // One polar result as the block presents it.
    typedef struct packed {
        logic [COORD_W-1:0] magnitude;
        logic [ANGLE_W-1:0] angle;
        logic               angle_valid;
    } polar_point_t;

    // One point to convert; typed rows carry their result written out by hand.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      typed;
        polar_point_t              want;
    } point_case_t;

    // A point in flight together with the result it must produce.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        polar_point_t              want;
    } pending_point_t;

    localparam polar_point_t NO_RESULT = '{16'd0, ANG_ZERO, 1'b0};

    // Axes, origin and extremes first, then the corners and points near the wrap.
    localparam point_case_t DIRECTED_POINTS [DIRECTED_N] = '{
        '{16'sd0,      16'sd0,      1'b1, '{16'd0,     ANG_ZERO,          1'b0}},
        '{16'sd0,      16'sd1,      1'b1, '{16'd1,     ANG_QUARTER,       1'b1}},
        '{16'sd0,      -16'sd1,     1'b1, '{16'd1,     ANG_THREE_QUARTER, 1'b1}},
        '{16'sd1,      16'sd0,      1'b1, '{16'd1,     ANG_ZERO,          1'b1}},
        '{-16'sd1,     16'sd0,      1'b1, '{16'd1,     ANG_HALF,          1'b1}},
        '{16'sd32767,  16'sd0,      1'b1, '{16'd32767, ANG_ZERO,          1'b1}},
        '{16'sh8000,   16'sd0,      1'b1, '{16'd32768, ANG_HALF,          1'b1}},
        '{16'sd0,      16'sd32767,  1'b1, '{16'd32767, ANG_QUARTER,       1'b1}},
        '{16'sd0,      16'sh8000,   1'b1, '{16'd32768, ANG_THREE_QUARTER, 1'b1}},
        '{16'sh8000,   16'sh8000,   1'b0, NO_RESULT},
        '{16'sd32767,  16'sd32767,  1'b0, NO_RESULT},
        '{16'sh8000,   16'sd32767,  1'b0, NO_RESULT},
        '{16'sd32767,  16'sh8000,   1'b0, NO_RESULT},
        '{16'sd1,      16'sd1,      1'b0, NO_RESULT},
        '{-16'sd1,     16'sd1,      1'b0, NO_RESULT},
        '{-16'sd1,     -16'sd1,     1'b0, NO_RESULT},
        '{16'sd1,      -16'sd1,     1'b0, NO_RESULT},
        '{16'sd32767,  -16'sd1,     1'b0, NO_RESULT},
        '{16'sh8000,   -16'sd1,     1'b0, NO_RESULT},
        '{16'sh8000,   16'sd1,      1'b0, NO_RESULT},
        '{16'sd1,      16'sd32767,  1'b0, NO_RESULT},
        '{16'sd3,      16'sd4,      1'b0, NO_RESULT},
        '{-16'sd21846, 16'sd21845,  1'b0, NO_RESULT},
        '{16'sd0,      16'sd0,      1'b1, '{16'd0,     ANG_ZERO,          1'b0}}
    };

    localparam logic signed [COORD_W-1:0] EDGE_COORDS [6] = '{
        16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
    };

    logic                      clk     = 1'b0;
    logic                      rst_n   = 1'b0;
    logic                      start   = 1'b0;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic                      busy;
    logic                      done;
    logic [COORD_W-1:0]        magnitude;
    logic [ANGLE_W-1:0]        angle;
    logic                      angle_valid;

    pending_point_t expected_polar[$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             idle_pct    = 0;

    cartesian_to_polar_top #(
        .COORD_WIDTH    (COORD_W),
        .ROTATION_STEPS (CORDIC_STEPS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .done        (done),
        .magnitude   (magnitude),
        .angle       (angle),
        .angle_valid (angle_valid)
    );

    // Free-running clock, 2 ns period.
    always #1 clk = ~clk;

    // Square root rounded to nearest, one result bit per pass.
    function automatic logic [COORD_W-1:0] nearest_root(input logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_w;
        rem   = radicand;
        root  = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (rem >= root + bit_w)
            begin
                rem  = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end
            else
            begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        if (rem > root)
            root = root + 1;
        return root[COORD_W-1:0];
    endfunction

    // Vectoring rotations: drives y toward zero and sums the turned angle.
    function automatic logic [31:0] vector_turns(input logic signed [COORD_W-1:0] xc,
                                                 input logic signed [COORD_W-1:0] yc);
        logic signed [63:0] xa;
        logic signed [63:0] ya;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic [31:0]        turns;
        xa    = xc;
        ya    = yc;
        turns = '0;
        // Left half plane: rotate by a half turn first.
        if (xa < 0)
        begin
            xa    = -xa;
            ya    = -ya;
            turns = TURN_HALF;
        end
        xa = xa <<< GUARD_BITS;
        ya = ya <<< GUARD_BITS;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            xs = xa >>> k;
            ys = ya >>> k;
            if (ya >= 0)
            begin
                xa    = xa + ys;
                ya    = ya - xs;
                turns = turns + ATAN_STEP_TURNS[k];
            end
            else
            begin
                xa    = xa - ys;
                ya    = ya + xs;
                turns = turns - ATAN_STEP_TURNS[k];
            end
        end
        return turns;
    endfunction

    // Expected magnitude and angle of one point.
    function automatic polar_point_t predict_polar(input logic signed [COORD_W-1:0] xc,
                                                   input logic signed [COORD_W-1:0] yc);
        polar_point_t       res;
        logic signed [63:0] xl;
        logic signed [63:0] yl;
        logic [31:0]        turns;
        xl = xc;
        yl = yc;
        res.magnitude   = nearest_root(64'(xl * xl + yl * yl));
        res.angle_valid = 1'b1;
        if (xc == 0 && yc == 0)
        begin
            res.angle       = ANG_ZERO;
            res.angle_valid = 1'b0;
        end
        else if (xc == 0)
        begin
            res.angle = (yc < 0) ? ANG_THREE_QUARTER : ANG_QUARTER;
        end
        else if (yc == 0)
        begin
            res.angle = (xc < 0) ? ANG_HALF : ANG_ZERO;
        end
        else
        begin
            // Round the 32-bit turn count to 16 bits; a full turn wraps to zero.
            turns     = vector_turns(xc, yc);
            res.angle = turns[31:16] + {15'd0, turns[15]};
        end
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Presents one point after a random idle stretch and holds it until taken.
    task automatic send_point(input point_case_t pc);
        pending_point_t entry;
        logic           taken;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        x_coord <= pc.x;
        y_coord <= pc.y;
        entry.x    = pc.x;
        entry.y    = pc.y;
        entry.want = pc.typed ? pc.want : predict_polar(pc.x, pc.y);
        taken = 1'b0;
        // Inputs and busy are stable from the falling edge to the next rising one.
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            if (taken)
                expected_polar = {expected_polar, entry};
            @(posedge clk);
        end
    endtask

    // Result checker: the strobe and fields are sampled mid-cycle.
    always @(negedge clk)
    begin
        pending_point_t exp_item;
        if (rst_n && done === 1'b1)
        begin
            if (expected_polar.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result mag %0d angle %h valid %b",
                                          magnitude, angle, angle_valid));
            end
            else
            begin
                exp_item = expected_polar.pop_front();
                if (magnitude !== exp_item.want.magnitude)
                    report_mismatch($sformatf("(%0d,%0d) magnitude %0d, expected %0d",
                                              exp_item.x, exp_item.y, magnitude,
                                              exp_item.want.magnitude));
                if (angle !== exp_item.want.angle)
                    report_mismatch($sformatf("(%0d,%0d) angle %h, expected %h",
                                              exp_item.x, exp_item.y, angle,
                                              exp_item.want.angle));
                if (angle_valid !== exp_item.want.angle_valid)
                    report_mismatch($sformatf("(%0d,%0d) angle_valid %b, expected %b",
                                              exp_item.x, exp_item.y, angle_valid,
                                              exp_item.want.angle_valid));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_polar.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: directed table, then three phases of random points.
    initial
    begin
        point_case_t pc;
        int          sel;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        for (int i = 0; i < DIRECTED_N; i++)
            send_point(DIRECTED_POINTS[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 20 : ((phase == 1) ? 71 : 0);
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                pc.typed = 1'b0;
                pc.want  = NO_RESULT;
                pc.x     = 16'($urandom);
                pc.y     = 16'($urandom);
                sel      = $urandom_range(9);
                case (sel)
                    // Small points around the origin, origin included.
                    5:
                    begin
                        pc.x = 16'($urandom_range(16)) - 16'sd8;
                        pc.y = 16'($urandom_range(16)) - 16'sd8;
                    end
                    // Points on one of the axes.
                    6:
                    begin
                        if ($urandom_range(1) == 0)
                            pc.x = '0;
                        else
                            pc.y = '0;
                    end
                    // Coordinates at or next to the range limits.
                    7:
                    begin
                        pc.x = EDGE_COORDS[$urandom_range(5)];
                        pc.y = EDGE_COORDS[$urandom_range(5)];
                    end
                    // Close to the x axis, where the angle wraps or crosses a half turn.
                    8:
                    begin
                        pc.y = 16'($urandom_range(6)) - 16'sd3;
                    end
                    // Close to the y axis.
                    9:
                    begin
                        pc.x = 16'($urandom_range(6)) - 16'sd3;
                    end
                    default:
                    begin
                    end
                endcase
                send_point(pc);
            end
        end
        start <= 1'b0;

        // Let the pipeline empty, then watch for stray results.
        while (expected_polar.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/c2p_pkg.sv
rtl/c2p_mag_pipe.sv
rtl/c2p_cordic_pipe.sv
rtl/cartesian_to_polar_top.sv
dv/cartesian_to_polar_top_tb.sv
